>>> src/pafc_pkg.sv
// ----------------------------------------------------------------------------
// pafc_pkg
// Shared widths, op codes and value-table codes for the partial assignment
// feasibility check.
// ----------------------------------------------------------------------------
package pafc_pkg;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 2;
  localparam int COEF_W  = 16;
  localparam int BOUND_W = 32;
  localparam int SUM_W   = 48;
  localparam int PROD_W  = COEF_W + VAL_W;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_TERM  = 1'b1
  } op_t;

  localparam logic [VAL_W-1:0] CODE_UNASSIGNED = 2'b11;

endpackage

>>> src/partial_assignment_feasibility_check.sv
// ----------------------------------------------------------------------------
// partial_assignment_feasibility_check
// Folds streamed constraint terms into minimum and maximum activity sums
// against a table of variable values and checks each constraint's bounds.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_valid / in_stall | op, var_index, var_value,
//          |           |                     | coefficient, bounds, last flags
//  out_    | output    | out_valid/out_stall | constraint_ok, all_feasible,
//          |           |                     | check_done
//
//  One beat is accepted per cycle while in_stall is low. A last term's
//  result is formed by the value table read into the term stage, then by
//  the accumulate and bound compare into the output register.
//  After reset the value table is swept to unassigned, one entry per cycle,
//  so in_stall stays high until the sweep is done.
//  A stalled result holds a last term in the term stage, which then stalls the input.
// ----------------------------------------------------------------------------
module partial_assignment_feasibility_check #(
  parameter int NUM_VARS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [pafc_pkg::IDX_W-1:0]           in_var_index,
  input  logic signed [pafc_pkg::VAL_W-1:0]    in_var_value,
  input  logic signed [pafc_pkg::COEF_W-1:0]   in_coefficient,
  input  logic signed [pafc_pkg::BOUND_W-1:0]  in_lower_bound,
  input  logic signed [pafc_pkg::BOUND_W-1:0]  in_upper_bound,
  input  logic                                 in_last_term,
  input  logic                                 in_last_constraint,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_constraint_ok,
  output logic                                 out_all_feasible,
  output logic                                 out_check_done
);
  import pafc_pkg::*;

  localparam int AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;
  localparam int RW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [VAL_W-1:0] mem [NUM_VARS];

  logic                    clr_busy_r;
  logic [AW-1:0]           clr_addr_r;
  logic                    in_acc;
  logic [XW-1:0]           idx_ext;
  logic [AW-1:0]           addr;
  logic                    in_range;

  logic                    s1_valid_r;
  logic                    s1_range_r;
  logic [VAL_W-1:0]        rd_r;
  logic signed [COEF_W-1:0]  s1_coef_r;
  logic signed [BOUND_W-1:0] s1_lb_r;
  logic signed [BOUND_W-1:0] s1_ub_r;
  logic                    s1_last_t_r;
  logic                    s1_last_c_r;
  logic                    s1_go;

  logic signed [SUM_W-1:0] min_sum_r;
  logic signed [SUM_W-1:0] max_sum_r;
  logic                    feas_r;
  logic                    out_valid_r;
  logic                    ok_r;
  logic                    all_r;
  logic                    done_r;

  logic [VAL_W-1:0]        code;
  logic signed [VAL_W-1:0] val_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0] d_min;
  logic signed [SUM_W-1:0] d_max;
  logic signed [SUM_W-1:0] min_nxt;
  logic signed [SUM_W-1:0] max_nxt;
  logic                    ok_nxt;
  logic                    all_nxt;

  assign idx_ext  = XW'(in_var_index);
  assign addr     = idx_ext[AW-1:0];
  assign in_range = (RW'(in_var_index) < RW'(NUM_VARS));

  assign s1_go    = s1_valid_r && (!s1_last_t_r || !out_valid_r || !out_stall);
  assign in_stall = clr_busy_r || (s1_valid_r && !s1_go);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= CODE_UNASSIGNED;
    end else if (in_acc && in_op == OP_WRITE && in_range) begin
      mem[addr] <= in_var_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_TERM && in_range) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_range_r  <= in_range;
      s1_coef_r   <= in_coefficient;
      s1_lb_r     <= in_lower_bound;
      s1_ub_r     <= in_upper_bound;
      s1_last_t_r <= in_last_term;
      s1_last_c_r <= in_last_constraint;
    end
  end

  always_comb begin
    code  = s1_range_r ? rd_r : CODE_UNASSIGNED;
    val_s = code;
    prod  = PROD_W'(s1_coef_r) * PROD_W'(val_s);
    if (code == CODE_UNASSIGNED) begin
      d_min = s1_coef_r[COEF_W-1] ? SUM_W'(s1_coef_r) : '0;
      d_max = s1_coef_r[COEF_W-1] ? '0 : SUM_W'(s1_coef_r);
    end else begin
      d_min = SUM_W'(prod);
      d_max = SUM_W'(prod);
    end
    min_nxt = min_sum_r + d_min;
    max_nxt = max_sum_r + d_max;
    ok_nxt  = !((min_nxt > SUM_W'(s1_ub_r)) || (SUM_W'(s1_lb_r) > max_nxt));
    all_nxt = feas_r && ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      min_sum_r   <= '0;
      max_sum_r   <= '0;
      feas_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_addr_r == AW'(NUM_VARS - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end
      if (in_acc && in_op == OP_TERM) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        if (s1_last_t_r) begin
          min_sum_r <= '0;
          max_sum_r <= '0;
          feas_r    <= s1_last_c_r ? 1'b1 : all_nxt;
        end else begin
          min_sum_r <= min_nxt;
          max_sum_r <= max_nxt;
        end
      end
      if (s1_go && s1_last_t_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_t_r) begin
      ok_r   <= ok_nxt;
      all_r  <= all_nxt;
      done_r <= s1_last_c_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_constraint_ok = ok_r;
  assign out_all_feasible  = all_r;
  assign out_check_done    = done_r;

endmodule

>>> src/pafc_checker.sv
// ----------------------------------------------------------------------------
// pafc_port_checks
// Port-level checks for the partial assignment feasibility check, bound to
// the top level.
// ----------------------------------------------------------------------------
module pafc_port_checks (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_constraint_ok,
  input logic out_all_feasible,
  input logic out_check_done
);

  logic fail_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_pend_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      fail_pend_r <= !out_check_done && !out_all_feasible;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_constraint_ok) &&
      $stable(out_all_feasible) && $stable(out_check_done))
    else $error("stalled result beat changed");

  a_ok_and: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_constraint_ok |-> !out_all_feasible)
    else $error("all_feasible set on a failing constraint");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fail_pend_r |-> !out_all_feasible)
    else $error("all_feasible recovered within a check");

  a_clear_after_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> in_stall && !out_valid)
    else $error("input taken during table clear");

endmodule

bind partial_assignment_feasibility_check pafc_port_checks u_pafc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_constraint_ok (out_constraint_ok),
  .out_all_feasible  (out_all_feasible),
  .out_check_done    (out_check_done)
);
